// File: rtl/core/chd_pkg.sv
// Package for the canonical Huffman decoder: command codes, queue item type,
// default sizes. Used by the interfaces, the front, the back and the top level.
package chd_pkg;

  localparam int MaxCodeLen = 32;
  localparam int SymbolBits = 16;
  localparam int ResultCap  = 32;
  localparam int QueueDepth = 2;

  // Input command codes
  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdLoad  = 2'd1;
  localparam logic [1:0] CmdWord  = 2'd2;

  // Operations that reach the back end
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WORD  = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [5:0]  code_length;
    logic [16:0] length_count;
    logic [31:0] stream_word;
  } item_t;

endpackage

// File: rtl/core/chd_if.sv
// Valid/ready channel interfaces of the canonical Huffman decoder.
// Depends on chd_pkg for the default symbol width.
interface chd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  code_length;
  logic [16:0] length_count;
  logic [31:0] stream_word;

  modport source (output valid, command, code_length, length_count, stream_word, input ready);
  modport sink   (input valid, command, code_length, length_count, stream_word, output ready);
endinterface

interface chd_out_if #(
  parameter int SYMBOL_BITS = chd_pkg::SymbolBits
);
  logic                   valid;
  logic                   ready;
  logic [SYMBOL_BITS-1:0] symbol;
  logic                   last;

  modport source (output valid, symbol, last, input ready);
  modport sink   (input valid, symbol, last, output ready);
endinterface

// File: rtl/core/canonical_huffman_decoder.sv
// Canonical Huffman decoder. Requests are queued two deep by the front end, so
// the input keeps flowing while the back end works. A clear or length load is
// applied in the idle state. The first stream word after a clear or load runs
// the table derivation (one forward and one backward sweep over the lengths).
// Each stream word then leaves the queue in the idle state and enters the bit
// buffer in the start state; each decoded symbol takes a limit compare and
// shift, then an offset add into the output register, up to 32 symbols per
// word; the decode state returns to idle once no symbol fits. A stalled output
// holds the back end. The user must write symbol_count only while idle; the
// block does not enforce it. Depends on chd_pkg, chd_if, chd_front, chd_back.
module canonical_huffman_decoder #(
  parameter int MAX_CODE_LEN = chd_pkg::MaxCodeLen,
  parameter int SYMBOL_BITS  = chd_pkg::SymbolBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chd_in_if.sink      in_i,
  chd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  chd_pkg::item_t item;
  logic           item_valid, item_pop;
  logic [31:0]    symbol_count_q;

  // symbol_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= 32'd1;
    end else if (cfg_we_i) begin
      symbol_count_q <= cfg_data_i;
    end
  end

  chd_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop)
  );

  chd_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .symbol_count_i(symbol_count_q),
    .out_o         (out_o)
  );

endmodule

// File: rtl/core/chd_front.sv
// Front end: accepts requests, drops those without effect, and queues the rest.
// Depends on chd_pkg and chd_in_if.
module chd_front #(
  parameter int MAX_CODE_LEN = chd_pkg::MaxCodeLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  chd_in_if.sink         in_i,
  output chd_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_pop_i
);

  localparam int PtrW = (chd_pkg::QueueDepth > 1) ? $clog2(chd_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(chd_pkg::QueueDepth + 1);

  chd_pkg::item_t queue_q [chd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  logic           len_ok, keep, push, pop;
  chd_pkg::item_t item_new;

  // Classify the incoming request
  always_comb begin
    len_ok = (in_i.code_length != 6'd0) && (in_i.code_length <= 6'(MAX_CODE_LEN));
    keep   = (in_i.command == chd_pkg::CmdClear) || (in_i.command == chd_pkg::CmdWord) ||
             ((in_i.command == chd_pkg::CmdLoad) && len_ok);
    item_new.op           = (in_i.command == chd_pkg::CmdClear) ? chd_pkg::OP_CLEAR :
                            (in_i.command == chd_pkg::CmdLoad)  ? chd_pkg::OP_LOAD :
                                                                  chd_pkg::OP_WORD;
    item_new.code_length  = in_i.code_length;
    item_new.length_count = in_i.length_count;
    item_new.stream_word  = in_i.stream_word;
  end

  assign in_i.ready   = (fill_q != CntW'(chd_pkg::QueueDepth));
  assign push         = in_i.valid && in_i.ready && keep;
  assign pop          = item_pop_i && item_valid_o;
  assign item_valid_o = (fill_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(chd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(chd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/chd_back.sv
// Back end: table storage, table derivation, bit buffer and symbol decode.
// Depends on chd_pkg and chd_out_if.
module chd_back #(
  parameter int MAX_CODE_LEN = chd_pkg::MaxCodeLen,
  parameter int SYMBOL_BITS  = chd_pkg::SymbolBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  chd_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  input  logic [31:0]    symbol_count_i,
  chd_out_if.source      out_o
);

  localparam int IdxW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int LenW = $clog2(MAX_CODE_LEN + 1);
  localparam int NW   = $clog2(chd_pkg::ResultCap + 1);
  localparam logic [32:0] LimitTop = 33'h1_0000_0000;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FWD    = 6'b000010,
    ST_BWD    = 6'b000100,
    ST_START  = 6'b001000,
    ST_DECODE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q;

  logic [16:0] count_q   [MAX_CODE_LEN];
  logic [31:0] offset_q  [MAX_CODE_LEN];
  logic [32:0] limit_q   [MAX_CODE_LEN];
  logic [32:0] aligned_q [MAX_CODE_LEN];

  logic            ready_q;
  logic [LenW-1:0] shortest_q, longest_q, prev_q, sel_q;
  logic [63:0]     buf_q, next_code_q;
  logic [6:0]      bits_q;
  logic [31:0]     done_q, base_q, word_q, code_q;
  logic [IdxW-1:0] idx_q;
  logic [32:0]     next_limit_q;
  logic [NW-1:0]   n_q;
  logic            last_q;
  logic                   out_valid_q, out_last_q;
  logic [SYMBOL_BITS-1:0] out_sym_q;

  logic [LenW-1:0] cur_len, sel_len;
  logic [16:0]     cnt_cur;
  logic [63:0]     shifted, nc_sum, nc_sat, appended;
  logic [32:0]     aligned;
  logic [31:0]     top, sym;
  logic            can_decode, out_free;

  // Derivation arithmetic for the current length
  always_comb begin
    cur_len = LenW'(idx_q) + 1'b1;
    cnt_cur = count_q[idx_q];
    shifted = (prev_q != '0) ? (next_code_q << (cur_len - prev_q)) : next_code_q;
    nc_sum  = shifted + 64'(cnt_cur);
    nc_sat  = (nc_sum > 64'(LimitTop)) ? 64'(LimitTop) : nc_sum;
    if (shifted >= (64'd1 << cur_len)) begin
      aligned = LimitTop;
    end else begin
      aligned = 33'(shifted << (7'd32 - 7'(cur_len)));
    end
  end

  // Parallel limit compares; the least qualifying length wins
  always_comb begin
    top     = buf_q[63:32];
    sel_len = longest_q;
    for (int i = MAX_CODE_LEN - 1; i >= 0; i--) begin
      if ((LenW'(i + 1) >= shortest_q) && (LenW'(i + 1) < longest_q) &&
          ({1'b0, top} < limit_q[i])) begin
        sel_len = LenW'(i + 1);
      end
    end
    can_decode = (n_q < NW'(chd_pkg::ResultCap)) && (bits_q >= 7'(longest_q)) &&
                 (done_q < symbol_count_i);
    appended   = buf_q | ({32'h0, word_q} << (7'd32 - bits_q));
    sym        = code_q + offset_q[IdxW'(sel_q - 1'b1)];
    out_free   = !out_valid_q || out_o.ready;
  end

  assign item_pop_o   = (state_q == ST_IDLE) && item_valid_i;
  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

  // Table payload stores
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FWD) begin
      offset_q[idx_q] <= (cnt_cur != '0) ? (base_q - shifted[31:0]) : 32'h0;
      if (cnt_cur != '0) begin
        aligned_q[idx_q] <= aligned;
      end
    end
    if (state_q == ST_BWD) begin
      limit_q[idx_q] <= next_limit_q;
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      word_q <= item_i.stream_word;
    end
    if ((state_q == ST_DECODE) && can_decode) begin
      code_q <= top >> (6'd32 - 6'(sel_len));
      sel_q  <= sel_len;
      last_q <= ((done_q + 32'd1) == symbol_count_i);
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_sym_q  <= sym[SYMBOL_BITS-1:0];
      out_last_q <= last_q;
    end
  end

  // Output valid: set on emit, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        count_q[i] <= '0;
      end
      ready_q      <= 1'b0;
      shortest_q   <= '0;
      longest_q    <= '0;
      prev_q       <= '0;
      buf_q        <= '0;
      bits_q       <= '0;
      done_q       <= '0;
      idx_q        <= '0;
      next_code_q  <= '0;
      base_q       <= '0;
      next_limit_q <= '0;
      n_q          <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            case (item_i.op)
              chd_pkg::OP_CLEAR: begin
                for (int i = 0; i < MAX_CODE_LEN; i++) begin
                  count_q[i] <= '0;
                end
                ready_q    <= 1'b0;
                shortest_q <= '0;
                longest_q  <= '0;
                buf_q      <= '0;
                bits_q     <= '0;
                done_q     <= '0;
              end
              chd_pkg::OP_LOAD: begin
                count_q[IdxW'(item_i.code_length - 6'd1)] <= item_i.length_count;
                ready_q <= 1'b0;
              end
              chd_pkg::OP_WORD: begin
                if (!ready_q) begin
                  idx_q       <= '0;
                  next_code_q <= '0;
                  base_q      <= '0;
                  prev_q      <= '0;
                  shortest_q  <= '0;
                  longest_q   <= '0;
                  state_q     <= ST_FWD;
                end else begin
                  state_q <= ST_START;
                end
              end
              default: ;
            endcase
          end
        end
        // Forward pass: first codes, offsets, aligned starts
        ST_FWD: begin
          if (cnt_cur != '0) begin
            base_q      <= base_q + 32'(cnt_cur);
            next_code_q <= nc_sat;
            prev_q      <= cur_len;
            longest_q   <= cur_len;
            if (shortest_q == '0) begin
              shortest_q <= cur_len;
            end
          end
          if (idx_q == IdxW'(MAX_CODE_LEN - 1)) begin
            next_limit_q <= LimitTop;
            state_q      <= ST_BWD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // Backward pass: limits, empty lengths take the next one
        ST_BWD: begin
          if (cnt_cur != '0) begin
            next_limit_q <= aligned_q[idx_q];
          end
          if (idx_q == '0) begin
            ready_q <= 1'b1;
            state_q <= ST_START;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        ST_START: begin
          if ((longest_q == '0) || (done_q >= symbol_count_i)) begin
            state_q <= ST_IDLE;
          end else begin
            if (bits_q <= 7'd32) begin
              buf_q  <= appended;
              bits_q <= bits_q + 7'd32;
            end
            n_q     <= '0;
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (can_decode) begin
            buf_q   <= buf_q << sel_len;
            bits_q  <= bits_q - 7'(sel_len);
            done_q  <= done_q + 32'd1;
            n_q     <= n_q + 1'b1;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_DECODE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench for the canonical Huffman decoder: directed and random requests,
// an in-file decoder predictor and an in-order symbol check.
// Depends on chd_pkg, chd_if and canonical_huffman_decoder.
module tb_top;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  code_length;
    logic [16:0] length_count;
    logic [31:0] stream_word;
  } req_t;

  typedef struct packed {
    logic [15:0] symbol;
    logic        last;
  } sym_t;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_data_i;

  chd_in_if  in_if ();
  chd_out_if out_if ();

  canonical_huffman_decoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor state
  logic [31:0] sym_total;
  logic [16:0] len_cnt [1:32];
  logic [31:0] sym_ofs [1:32];
  logic [32:0] len_lim [1:32];
  bit          tbl_ok;
  int          min_len, max_len;
  logic [63:0] bitbuf;
  int          nbits;
  logic [31:0] n_done;

  req_t pending_reqs[$];
  sym_t expected_syms[$];
  int   errors;
  int   idle_cycles;
  bit   hold_out;

  task automatic wipe_state();
    for (int l = 1; l <= 32; l++) begin
      len_cnt[l] = '0; sym_ofs[l] = '0; len_lim[l] = '0;
    end
    tbl_ok = 0; min_len = 0; max_len = 0; bitbuf = '0; nbits = 0; n_done = '0;
  endtask

  task automatic build_tables();
    logic [63:0] first [1:32];
    logic [63:0] nxt;
    logic [31:0] base;
    logic [32:0] lim;
    int prev;
    nxt = '0; base = '0; prev = 0; lim = 33'h1_0000_0000;
    min_len = 0; max_len = 0;
    for (int l = 1; l <= 32; l++) begin
      first[l] = '0; sym_ofs[l] = '0; len_lim[l] = 33'h1_0000_0000;
      if (len_cnt[l] != 0) begin
        if (min_len == 0) min_len = l;
        max_len = l;
      end
    end
    for (int l = 1; l <= 32; l++) begin
      if (len_cnt[l] != 0) begin
        // nxt stays at or below 2^32 before the shift, so 64 bits hold it
        if (prev != 0) nxt = nxt << (l - prev);
        first[l] = nxt;
        sym_ofs[l] = base - nxt[31:0];
        base += 32'(len_cnt[l]);
        nxt = nxt + 64'(len_cnt[l]);
        if (nxt > 64'h1_0000_0000) nxt = 64'h1_0000_0000;
        prev = l;
      end
    end
    for (int l = 32; l >= 1; l--) begin
      len_lim[l] = lim;
      if (len_cnt[l] != 0) begin
        if (first[l] >= (64'd1 << l)) lim = 33'h1_0000_0000;
        else lim = 33'(first[l] << (32 - l));
      end
    end
    tbl_ok = 1;
  endtask

  // Work out the symbols one accepted request produces
  task automatic decode_request(req_t r);
    logic [31:0] top;
    logic [31:0] s;
    int l, n;
    n = 0;
    case (r.command)
      chd_pkg::CmdClear: wipe_state();
      chd_pkg::CmdLoad: begin
        if (r.code_length >= 1 && r.code_length <= 32) begin
          len_cnt[r.code_length] = r.length_count;
          tbl_ok = 0;
        end
      end
      chd_pkg::CmdWord: begin
        if (!tbl_ok) build_tables();
        if (max_len != 0 && n_done < sym_total) begin
          if (nbits <= 32) begin
            bitbuf |= {32'b0, r.stream_word} << (32 - nbits);
            nbits += 32;
          end
          while (n < chd_pkg::ResultCap && nbits >= max_len && n_done < sym_total) begin
            top = bitbuf[63:32];
            l = min_len;
            while (l < max_len && {1'b0, top} >= len_lim[l]) l++;
            s = (top >> (32 - l)) + sym_ofs[l];
            bitbuf = bitbuf << l;
            nbits -= l;
            n_done++;
            expected_syms.push_back('{symbol: s[15:0], last: n_done == sym_total});
            n++;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offers queued requests with random gaps
  int gap_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 0; gap_left <= 0;
      in_if.command <= chd_pkg::CmdClear; in_if.code_length <= '0;
      in_if.length_count <= '0; in_if.stream_word <= '0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold the request
    end else if (gap_left > 0) begin
      in_if.valid <= 0; gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      req_t r;
      r = pending_reqs.pop_front();
      in_if.valid <= 1;
      in_if.command <= r.command; in_if.code_length <= r.code_length;
      in_if.length_count <= r.length_count; in_if.stream_word <= r.stream_word;
      gap_left <= pick_gap();
    end else begin
      in_if.valid <= 0;
    end
  end

  // Receiver ready with random stalls, plus a forced long hold
  int stall_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 0; stall_left <= 0;
    end else if (hold_out) begin
      out_if.ready <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 0; stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1;
      stall_left <= pick_gap();
    end
  end

  // Predict on accepted requests, check symbols at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        decode_request('{in_if.command, in_if.code_length, in_if.length_count,
                         in_if.stream_word});
      if (out_if.valid && out_if.ready) begin
        if (expected_syms.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected symbol %0h last %0b",
                                     out_if.symbol, out_if.last);
        end else begin
          sym_t e;
          e = expected_syms.pop_front();
          if (e.symbol !== out_if.symbol || e.last !== out_if.last) begin
            errors++;
            if (errors <= 10) $display("symbol mismatch: exp %0h/%0b got %0h/%0b",
                                       e.symbol, e.last, out_if.symbol, out_if.last);
          end
        end
      end
      // Watchdog on cycles with no traffic
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else if (!hold_out) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_req(logic [1:0] c, logic [5:0] l, logic [16:0] n, logic [31:0] w);
    pending_reqs.push_back('{c, l, n, w});
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_if.valid || expected_syms.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_count(logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sym_total = v;
  endtask

  // Load a random code: counts drawn from a Kraft budget, the longest length takes the rest up to 65536
  task automatic load_random_code(int maxl);
    logic [33:0] room;
    int c;
    push_req(chd_pkg::CmdClear, 0, 0, 0);
    room = 1;
    for (int l = 1; l <= maxl; l++) begin
      room = room << 1;
      c = (l == maxl) ? int'(room > 65536 ? 65536 : room)
                      : $urandom_range(0, room > 3 ? 3 : int'(room) - 1);
      room -= 34'(c);
      if (c != 0 || $urandom_range(0, 3) == 0)
        push_req(chd_pkg::CmdLoad, 6'(l), 17'(c), 0);
    end
  endtask

  initial begin
    errors = 0; idle_cycles = 0; hold_out = 0;
    cfg_we_i = 0; cfg_data_i = '0;
    sym_total = 1;
    wipe_state();
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: one-bit code, 32 symbols per word, last flag at count
    write_count(32'd40);
    push_req(chd_pkg::CmdWord, 0, 0, 32'hFFFF_FFFF);   // no codes: discarded
    push_req(chd_pkg::CmdLoad, 1, 2, 0);
    push_req(chd_pkg::CmdLoad, 0, 5, 0);               // bad length: ignored
    push_req(chd_pkg::CmdLoad, 33, 5, 0);
    push_req(2'd3, 6'h3F, 17'h1FFFF, 32'hFFFF_FFFF);   // unknown command
    push_req(chd_pkg::CmdWord, 0, 0, 32'hA5A5_5A5A);
    push_req(chd_pkg::CmdWord, 0, 0, 32'hFFFF_0000);
    push_req(chd_pkg::CmdWord, 0, 0, 32'h0);           // after all done: discarded
    wait_idle();

    // Directed: 32-bit code lengths, oversubscribed table, max counts
    write_count(32'hFFFF_FFFF);
    push_req(chd_pkg::CmdClear, 0, 0, 0);
    push_req(chd_pkg::CmdLoad, 32, 17'h10000, 0);
    push_req(chd_pkg::CmdLoad, 2, 17'h1FFFF, 0);       // oversubscribed
    push_req(chd_pkg::CmdWord, 0, 0, 32'hFFFF_FFFF);
    push_req(chd_pkg::CmdWord, 0, 0, 32'h8000_0001);
    push_req(chd_pkg::CmdLoad, 2, 1, 0);               // reload mid-stream
    push_req(chd_pkg::CmdWord, 0, 0, 32'h1234_5678);
    push_req(chd_pkg::CmdWord, 0, 0, 32'hDEAD_BEEF);
    wait_idle();

    // Zero symbol count: nothing emitted
    write_count(32'd0);
    push_req(chd_pkg::CmdClear, 0, 0, 0);
    push_req(chd_pkg::CmdLoad, 3, 8, 0);
    push_req(chd_pkg::CmdWord, 0, 0, 32'h7777_7777);
    wait_idle();

    // Random phases; a long receiver hold in the second one
    for (int ph = 0; ph < 6; ph++) begin
      write_count(ph == 5 ? 32'hFFFF_FFFF : $urandom_range(20, 200));
      load_random_code($urandom_range(1, ph == 3 ? 32 : 12));
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 19) == 0)
          push_req(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                   17'($urandom_range(0, 17'h1FFFF)), $urandom());
        else
          push_req(chd_pkg::CmdWord, 0, 0, $urandom());
      end
      if (ph == 1) begin
        hold_out = 1;
        repeat (400) @(posedge clk_i);
        hold_out = 0;
      end
      wait_idle();
    end

    if (errors == 0 && expected_syms.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/chd_pkg.sv
rtl/core/chd_if.sv
rtl/core/chd_front.sv
rtl/core/chd_back.sv
rtl/core/canonical_huffman_decoder.sv
verif/tb_top.sv
